// ----- rtl/tpr_pkg.sv -----
// Package for the token pairing relay table: action codes, state type,
// query records that travel along the cell chains, and the code trim function.
`timescale 1ns / 1ps
package tpr_pkg;

	localparam int CODE_W     = 152;
	localparam int CODE_BYTES = 19;
	localparam int TOK_IDX_W  = 8;
	localparam int PAIR_IDX_W = 10;
	localparam int PAIR_CNT_W = 11;

	localparam logic [2:0] ACT_STORED   = 3'd0;
	localparam logic [2:0] ACT_PAIRED   = 3'd1;
	localparam logic [2:0] ACT_FORWARD  = 3'd2;
	localparam logic [2:0] ACT_NOROUTE  = 3'd3;
	localparam logic [2:0] ACT_TOKFULL  = 3'd4;
	localparam logic [2:0] ACT_LINKFULL = 3'd5;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_BUSY,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic                 valid;
		logic [CODE_W-1:0]    code;
		logic [31:0]          ip;
		logic [15:0]          port;
		logic                 matched;
		logic [TOK_IDX_W-1:0] m_idx;
		logic [31:0]          m_ip;
		logic [15:0]          m_port;
		logic                 free;
		logic [TOK_IDX_W-1:0] f_idx;
	} tok_query_t;

	typedef struct packed {
		logic                  valid;
		logic [31:0]           ip;
		logic [15:0]           port;
		logic                  hit;
		logic [PAIR_IDX_W-1:0] idx;
		logic [31:0]           dip;
		logic [15:0]           dport;
	} pair_query_t;

	function automatic logic [CODE_W-1:0] trim_code(input logic [CODE_W-1:0] raw);
		logic [CODE_W-1:0] res;
		logic              ended;
		res   = raw;
		ended = 1'b0;
		for (int i = 0; i < CODE_BYTES; i++) begin
			if (ended) begin
				res[i*8 +: 8] = 8'h00;
			end else if (raw[i*8 +: 8] == 8'h00) begin
				ended = 1'b1;
			end
		end
		return res;
	endfunction

endpackage

// ----- rtl/tpr_if.sv -----
// Handshake channels of the relay table: datagram header in, result out.
// Uses no package.
`timescale 1ns / 1ps
interface tpr_in_if;
	logic        valid;
	logic        ready;
	logic [31:0] src_ip;
	logic [15:0] src_port;
	logic        is_token;
	logic [63:0] code_bytes_low;
	logic [63:0] code_bytes_mid;
	logic [23:0] code_bytes_high;

	modport source (output valid, src_ip, src_port, is_token, code_bytes_low,
		code_bytes_mid, code_bytes_high, input ready);
	modport sink (input valid, src_ip, src_port, is_token, code_bytes_low,
		code_bytes_mid, code_bytes_high, output ready);
endinterface

interface tpr_out_if;
	logic        valid;
	logic        ready;
	logic [2:0]  action;
	logic [31:0] dest_ip;
	logic [15:0] dest_port;
	logic [4:0]  entry_index;

	modport source (output valid, action, dest_ip, dest_port, entry_index, input ready);
	modport sink (input valid, action, dest_ip, dest_port, entry_index, output ready);
endinterface

// ----- rtl/token_pairing_relay_table_core.sv -----
// Top level of the token pairing relay table: sequencer, pair count and the
// two cell chains. Depends on tpr_pkg, tpr_if, tpr_token_cell, tpr_pair_cell.
//
//  channel  | dir | handshake     | payload
//  in_ch    | in  | valid/ready   | src_ip, src_port, is_token, code_bytes_*
//  out_ch   | out | valid/ready   | action, dest_ip, dest_port, entry_index
//
// One item at a time. A token item walks the pending chain and a payload
// item walks the pair chain, one cell per cycle. The next item is taken in
// the cycle after the result leaves.
// Reset empties the pending slots and the link table at once.
// A stalled result holds in the output register until taken.
`timescale 1ns / 1ps
module token_pairing_relay_table_core
	import tpr_pkg::*;
#(
	parameter int TOKEN_SLOTS = 16,
	parameter int PAIR_SLOTS  = 32
) (
	input logic       clk,
	input logic       arst_n,
	tpr_in_if.sink    in_ch,
	tpr_out_if.source out_ch
);

	localparam logic [PAIR_CNT_W-1:0] PAIR_FULL = PAIR_CNT_W'(PAIR_SLOTS);

	state_t                state_q;
	state_t                state_next;
	logic [PAIR_CNT_W-1:0] pair_count_q;
	logic [2:0]            action_q;
	logic [31:0]           dest_ip_q;
	logic [15:0]           dest_port_q;
	logic [4:0]            entry_index_q;

	tok_query_t            tq [TOKEN_SLOTS+1];
	pair_query_t           pq [PAIR_SLOTS+1];
	tok_query_t            tt;
	pair_query_t           pt;
	logic                  accept;
	logic                  tok_wr;
	logic                  tok_clr;
	logic                  pair_wr;

	assign accept = in_ch.valid && in_ch.ready;
	assign tt     = tq[TOKEN_SLOTS];
	assign pt     = pq[PAIR_SLOTS];

	always_comb begin
		tq[0]         = '0;
		tq[0].valid   = accept && in_ch.is_token;
		tq[0].code    = trim_code({in_ch.code_bytes_high, in_ch.code_bytes_mid,
			in_ch.code_bytes_low});
		tq[0].ip      = in_ch.src_ip;
		tq[0].port    = in_ch.src_port;
		pq[0]         = '0;
		pq[0].valid   = accept && !in_ch.is_token;
		pq[0].ip      = in_ch.src_ip;
		pq[0].port    = in_ch.src_port;
	end

	assign tok_wr  = tt.valid && !tt.matched && tt.free;
	assign pair_wr = tt.valid && tt.matched && pair_count_q != PAIR_FULL;
	assign tok_clr = pair_wr;

	for (genvar i = 0; i < TOKEN_SLOTS; i++) begin : g_tok
		tpr_token_cell #(.IDX(i)) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.q_in    (tq[i]),
			.q_out   (tq[i+1]),
			.wr_en   (tok_wr),
			.wr_idx  (tt.f_idx),
			.clr_en  (tok_clr),
			.clr_idx (tt.m_idx),
			.wr_code (tt.code),
			.wr_ip   (tt.ip),
			.wr_port (tt.port)
		);
	end

	for (genvar j = 0; j < PAIR_SLOTS; j++) begin : g_pair
		tpr_pair_cell #(.IDX(j)) u_cell (
			.clk            (clk),
			.arst_n         (arst_n),
			.q_in           (pq[j]),
			.q_out          (pq[j+1]),
			.count          (pair_count_q),
			.wr_en          (pair_wr),
			.wr_idx         (pair_count_q),
			.wr_first_ip    (tt.m_ip),
			.wr_first_port  (tt.m_port),
			.wr_second_ip   (tt.ip),
			.wr_second_port (tt.port)
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			pair_count_q <= '0;
		end else begin
			state_q <= state_next;
			if (pair_wr) begin
				pair_count_q <= pair_count_q + PAIR_CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (tt.valid) begin
			dest_ip_q   <= '0;
			dest_port_q <= '0;
			if (tt.matched) begin
				if (pair_count_q == PAIR_FULL) begin
					action_q      <= ACT_LINKFULL;
					entry_index_q <= '0;
				end else begin
					action_q      <= ACT_PAIRED;
					entry_index_q <= pair_count_q[4:0];
				end
			end else if (tt.free) begin
				action_q      <= ACT_STORED;
				entry_index_q <= tt.f_idx[4:0];
			end else begin
				action_q      <= ACT_TOKFULL;
				entry_index_q <= '0;
			end
		end else if (pt.valid) begin
			if (pt.hit) begin
				action_q      <= ACT_FORWARD;
				dest_ip_q     <= pt.dip;
				dest_port_q   <= pt.dport;
				entry_index_q <= pt.idx[4:0];
			end else begin
				action_q      <= ACT_NOROUTE;
				dest_ip_q     <= '0;
				dest_port_q   <= '0;
				entry_index_q <= '0;
			end
		end
	end

	always_comb begin
		state_next = state_q;
		unique case (state_q)
			ST_IDLE: if (accept) state_next = ST_BUSY;
			ST_BUSY: if (tt.valid || pt.valid) state_next = ST_DONE;
			ST_DONE: if (out_ch.ready) state_next = ST_IDLE;
			default: state_next = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ch.ready        = state_q == ST_IDLE;
		out_ch.valid       = state_q == ST_DONE;
		out_ch.action      = action_q;
		out_ch.dest_ip     = dest_ip_q;
		out_ch.dest_port   = dest_port_q;
		out_ch.entry_index = entry_index_q;
	end

	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ch.ready && out_ch.valid))
		else $error("input taken while a result waits");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pair_count_q <= PAIR_FULL)
		else $error("pair count beyond table size");

	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !in_ch.ready)
		else $error("second item taken during a walk");

	a_no_dest: assert property (@(posedge clk) disable iff (!arst_n)
		(out_ch.valid && out_ch.action != ACT_FORWARD) |->
		(out_ch.dest_ip == '0 && out_ch.dest_port == '0))
		else $error("destination set on a non-forward result");

endmodule

// ----- rtl/tpr_token_cell.sv -----
// One pending-token slot: holds code and owner, checks the passing query.
// Depends on tpr_pkg.
`timescale 1ns / 1ps
module tpr_token_cell
	import tpr_pkg::*;
#(
	parameter int IDX = 0
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  tok_query_t           q_in,
	output tok_query_t           q_out,
	input  logic                 wr_en,
	input  logic [TOK_IDX_W-1:0] wr_idx,
	input  logic                 clr_en,
	input  logic [TOK_IDX_W-1:0] clr_idx,
	input  logic [CODE_W-1:0]    wr_code,
	input  logic [31:0]          wr_ip,
	input  logic [15:0]          wr_port
);

	localparam logic [TOK_IDX_W-1:0] MY_IDX = TOK_IDX_W'(IDX);

	logic              valid_q;
	logic [CODE_W-1:0] code_q;
	logic [31:0]       ip_q;
	logic [15:0]       port_q;
	tok_query_t        q_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (wr_en && wr_idx == MY_IDX) begin
			valid_q <= 1'b1;
		end else if (clr_en && clr_idx == MY_IDX) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en && wr_idx == MY_IDX) begin
			code_q <= wr_code;
			ip_q   <= wr_ip;
			port_q <= wr_port;
		end
	end

	always_comb begin
		q_next = q_in;
		if (!q_in.matched && valid_q && code_q == q_in.code) begin
			q_next.matched = 1'b1;
			q_next.m_idx   = MY_IDX;
			q_next.m_ip    = ip_q;
			q_next.m_port  = port_q;
		end
		if (!q_in.free && !valid_q) begin
			q_next.free  = 1'b1;
			q_next.f_idx = MY_IDX;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			q_out.valid <= 1'b0;
		end else begin
			q_out <= q_next;
		end
	end

endmodule

// ----- rtl/tpr_pair_cell.sv -----
// One link-table pair: holds both endpoints, checks the passing lookup.
// Depends on tpr_pkg.
`timescale 1ns / 1ps
module tpr_pair_cell
	import tpr_pkg::*;
#(
	parameter int IDX = 0
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  pair_query_t           q_in,
	output pair_query_t           q_out,
	input  logic [PAIR_CNT_W-1:0] count,
	input  logic                  wr_en,
	input  logic [PAIR_CNT_W-1:0] wr_idx,
	input  logic [31:0]           wr_first_ip,
	input  logic [15:0]           wr_first_port,
	input  logic [31:0]           wr_second_ip,
	input  logic [15:0]           wr_second_port
);

	localparam logic [PAIR_CNT_W-1:0] MY_IDX = PAIR_CNT_W'(IDX);

	logic [31:0] first_ip_q;
	logic [15:0] first_port_q;
	logic [31:0] second_ip_q;
	logic [15:0] second_port_q;
	logic        active;
	pair_query_t q_next;

	always_ff @(posedge clk) begin
		if (wr_en && wr_idx == MY_IDX) begin
			first_ip_q    <= wr_first_ip;
			first_port_q  <= wr_first_port;
			second_ip_q   <= wr_second_ip;
			second_port_q <= wr_second_port;
		end
	end

	assign active = MY_IDX < count;

	always_comb begin
		q_next = q_in;
		if (!q_in.hit && active) begin
			if (first_ip_q == q_in.ip && first_port_q == q_in.port) begin
				q_next.hit   = 1'b1;
				q_next.idx   = MY_IDX[PAIR_IDX_W-1:0];
				q_next.dip   = second_ip_q;
				q_next.dport = second_port_q;
			end else if (second_ip_q == q_in.ip && second_port_q == q_in.port) begin
				q_next.hit   = 1'b1;
				q_next.idx   = MY_IDX[PAIR_IDX_W-1:0];
				q_next.dip   = first_ip_q;
				q_next.dport = first_port_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			q_out.valid <= 1'b0;
		end else begin
			q_out <= q_next;
		end
	end

endmodule
